FILE: hdl/crcrx_pkg.sv
// ---------------------------------------------------------------------------
// crcrx_pkg - shared constants for the reply frame receiver
// Action codes, status codes, register indexes and frame constants.
// ---------------------------------------------------------------------------
package crcrx_pkg;

  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned FIELD_IDX_W = 3;
  localparam int unsigned VALUE_W     = 16;

  localparam int unsigned MAX_FIELDS     = 8;
  localparam int unsigned CRC_TEXT_CHARS = 4;

  localparam logic [FIELD_IDX_W-1:0] LAST_FIELD = FIELD_IDX_W'(MAX_FIELDS - 1);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ARM  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CRC_BAD   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FRAME_TO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_REPLY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_CRC_SEP = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_CHAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TO  = 3'd4;

  // CRC-16/XMODEM
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] CHAR_PIPE  = 8'h7C;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_K     = 8'h4B;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

endpackage

FILE: hdl/crc_checked_reply_frame_receiver_unit.sv
// ---------------------------------------------------------------------------
// crc_checked_reply_frame_receiver_unit - CRC checked reply frame receiver
// Collects a framed reply byte by byte, parses decimal fields, checks the
// CRC-16/XMODEM hex text and reports fields or an error status.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  cfg       in         cfg_we_i                  cfg_index_i, cfg_data_i
//  in        in         in_valid_i / in_ready_o   action_i, rx_byte_i
//  out       out        out_valid_o / out_ready_i status_o, field_index_o,
//                                                 field_value_o, first_is_ok_o,
//                                                 last_o
//
// A payload byte is accepted, decoded, then shifted through the bit-serial
// CRC register. Other items are accepted and decoded. end_char with CRC text
// adds a nibble-serial text compare. Every result, error or field, passes
// through S_EMIT and waits there while the output register is stalled.
// Reset clears all control state; field and CRC text stores are not cleared.
// A stalled result holds in the output register; decode still runs ahead of
// it until the next result needs the register.
// ---------------------------------------------------------------------------
module crc_checked_reply_frame_receiver_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [crcrx_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [crcrx_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [crcrx_pkg::ACTION_W-1:0]        action_i,
  input  logic [7:0]                            rx_byte_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [crcrx_pkg::STATUS_W-1:0]        status_o,
  output logic [crcrx_pkg::FIELD_IDX_W-1:0]     field_index_o,
  output logic signed [crcrx_pkg::VALUE_W-1:0]  field_value_o,
  output logic                                  first_is_ok_o,
  output logic                                  last_o
);
  import crcrx_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_CRC, S_CHECK, S_EMIT} seq_e;
  typedef enum logic [1:0] {PH_WAIT, PH_PAYLOAD, PH_CRCTEXT, PH_DONE} phase_e;
  typedef enum logic [1:0] {NP_LEAD, NP_SIGN, NP_DIGITS, NP_END} np_e;
  typedef enum logic [1:0] {OK_NONE, OK_GOT_O, OK_GOT_OK, OK_FAIL} okm_e;

  localparam logic [1:0] CHECK_LAST = 2'(CRC_TEXT_CHARS - 1);

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    c = (nib < 4'd10) ? (8'd48 + {4'd0, nib}) : (8'd87 + {4'd0, nib});
    return c;
  endfunction

  seq_e   state_q, state_d;
  phase_e phase_q, phase_d;
  np_e    np_q, np_d;
  okm_e   ok_q, ok_d;

  logic [7:0]  start_char_q, end_char_q, sep_char_q;
  logic [15:0] frame_to_q, answer_to_q;

  logic [ACTION_W-1:0] act_q, act_d;
  logic [7:0]          byte_q, byte_d;

  logic [15:0] tick_q, tick_d;
  logic [15:0] crc_q, crc_d;
  logic [2:0]  text_cnt_q, text_cnt_d;
  logic [FIELD_IDX_W-1:0] field_cnt_q, field_cnt_d;
  logic [15:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [FIELD_IDX_W-1:0] emit_idx_q, emit_idx_d;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  chk_pos_q, chk_pos_d;
  logic [1:0]  chk_cnt_q, chk_cnt_d;
  logic        chk_started_q, chk_started_d;
  logic        chk_bad_q, chk_bad_d;
  logic        res_err_q, res_err_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;

  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic [FIELD_IDX_W-1:0]  field_index_q, field_index_d;
  logic [VALUE_W-1:0]      field_value_q, field_value_d;
  logic                    first_ok_q, first_ok_d;
  logic                    last_q, last_d;

  // stores, undefined until written
  logic [VALUE_W-1:0] store_q [MAX_FIELDS];
  logic [7:0]         text_q [CRC_TEXT_CHARS];

  logic                   store_we;
  logic [FIELD_IDX_W-1:0] store_idx;
  logic [VALUE_W-1:0]     store_wdata;
  logic                   text_we;

  logic        slot_free;
  logic        is_digit, is_space, take_digit;
  logic [15:0] tick_next;
  logic [18:0] mag10;
  logic [15:0] mag_sat;
  logic [3:0]  nib;
  logic        take_nib;
  logic        fb;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_digit  = (byte_q >= 8'd48) && (byte_q <= 8'd57);
  assign is_space  = (byte_q == 8'd32) || ((byte_q >= 8'd9) && (byte_q <= 8'd13));
  assign tick_next = (tick_q == 16'hFFFF) ? tick_q : (tick_q + 16'd1);
  assign mag10     = ({3'd0, mag_q} << 3) + ({3'd0, mag_q} << 1) + {15'd0, byte_q[3:0]};
  assign mag_sat   = (mag10 > 19'd32768) ? 16'h8000 : mag10[15:0];
  assign nib       = crc_q[15:12];
  assign take_nib  = (nib != 4'd0) || chk_started_q || (chk_cnt_q == CHECK_LAST);
  assign fb        = crc_q[15] ^ shift_q[7];

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    np_d          = np_q;
    ok_d          = ok_q;
    act_d         = act_q;
    byte_d        = byte_q;
    tick_d        = tick_q;
    crc_d         = crc_q;
    text_cnt_d    = text_cnt_q;
    field_cnt_d   = field_cnt_q;
    mag_d         = mag_q;
    neg_d         = neg_q;
    emit_idx_d    = emit_idx_q;
    bit_cnt_d     = bit_cnt_q;
    shift_d       = shift_q;
    chk_pos_d     = chk_pos_q;
    chk_cnt_d     = chk_cnt_q;
    chk_started_d = chk_started_q;
    chk_bad_d     = chk_bad_q;
    res_err_d     = res_err_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    status_d      = status_q;
    field_index_d = field_index_q;
    field_value_d = field_value_q;
    first_ok_d    = first_ok_q;
    last_d        = last_q;
    store_we      = 1'b0;
    store_idx     = field_cnt_q;
    store_wdata   = '0;
    text_we       = 1'b0;
    take_digit    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          byte_d  = rx_byte_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_IDLE;
        if (act_q == ACT_ARM) begin
          phase_d = PH_WAIT;
          tick_d  = '0;
        end else if (act_q == ACT_TICK) begin
          if (phase_q != PH_DONE) begin
            tick_d = tick_next;
            if (phase_q == PH_WAIT) begin
              if (tick_next >= answer_to_q) begin
                res_err_d = 1'b1; res_status_d = ST_NO_REPLY;
                phase_d = PH_DONE; state_d = S_EMIT;
              end
            end else if (tick_next > frame_to_q) begin
              res_err_d = 1'b1; res_status_d = ST_FRAME_TO;
              phase_d = PH_DONE; state_d = S_EMIT;
            end
          end
        end else if (act_q == ACT_BYTE) begin
          if (phase_q == PH_WAIT) begin
            if (byte_q == start_char_q) begin
              phase_d     = PH_PAYLOAD;
              tick_d      = '0;
              crc_d       = '0;
              text_cnt_d  = '0;
              field_cnt_d = '0;
              ok_d        = OK_NONE;
              np_d        = NP_LEAD;
              mag_d       = '0;
              neg_d       = 1'b0;
              store_we    = 1'b1;
              store_idx   = '0;
            end
          end else if (phase_q != PH_DONE) begin
            if (byte_q == end_char_q) begin
              phase_d = PH_DONE;
              if (phase_q == PH_PAYLOAD) begin
                res_err_d = 1'b1; res_status_d = ST_NO_CRC_SEP;
                state_d = S_EMIT;
              end else begin
                chk_cnt_d = '0; chk_pos_d = '0;
                chk_started_d = 1'b0; chk_bad_d = 1'b0;
                state_d = S_CHECK;
              end
            end else if (phase_q == PH_CRCTEXT) begin
              if (text_cnt_q < 3'(CRC_TEXT_CHARS)) begin
                text_we    = 1'b1;
                text_cnt_d = text_cnt_q + 3'd1;
              end
            end else if (byte_q == CHAR_PIPE) begin
              phase_d = PH_CRCTEXT;
            end else begin
              shift_d   = byte_q;
              bit_cnt_d = '0;
              state_d   = S_CRC;
              if (byte_q == sep_char_q && field_cnt_q != LAST_FIELD) begin
                field_cnt_d = field_cnt_q + 1'b1;
                np_d        = NP_LEAD;
                mag_d       = '0;
                neg_d       = 1'b0;
                store_we    = 1'b1;
                store_idx   = field_cnt_q + 1'b1;
              end else begin
                case (np_q)
                  NP_LEAD: begin
                    if (!is_space) begin
                      if (byte_q == CHAR_PLUS || byte_q == CHAR_MINUS) begin
                        neg_d = (byte_q == CHAR_MINUS);
                        np_d  = NP_SIGN;
                      end else if (!is_digit) begin
                        np_d = NP_END;
                      end else begin
                        take_digit = 1'b1;
                      end
                    end
                  end
                  NP_SIGN, NP_DIGITS: begin
                    if (!is_digit) np_d = NP_END;
                    else take_digit = 1'b1;
                  end
                  default: ;
                endcase
                if (take_digit) begin
                  np_d     = NP_DIGITS;
                  mag_d    = mag_sat;
                  store_we = 1'b1;
                  if (neg_q) store_wdata = 16'd0 - mag_sat;
                  else store_wdata = mag_sat[15] ? 16'h7FFF : mag_sat;
                end
                if (field_cnt_q == '0) begin
                  case (ok_q)
                    OK_NONE:  ok_d = (byte_q == CHAR_O) ? OK_GOT_O : OK_FAIL;
                    OK_GOT_O: ok_d = (byte_q == CHAR_K) ? OK_GOT_OK : OK_FAIL;
                    default:  ok_d = OK_FAIL;
                  endcase
                end
              end
            end
          end
        end
      end

      // one message bit per cycle, MSB first
      S_CRC: begin
        crc_d     = {crc_q[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        shift_d   = {shift_q[6:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 3'd1;
        if (bit_cnt_q == 3'd7) state_d = S_IDLE;
      end

      // one hex digit per cycle, leading zeros skipped, CRC rotated back
      S_CHECK: begin
        if (take_nib) begin
          chk_started_d = 1'b1;
          chk_pos_d     = chk_pos_q + 3'd1;
          if (chk_pos_q >= text_cnt_q || text_q[chk_pos_q[1:0]] != hex_char(nib))
            chk_bad_d = 1'b1;
        end
        crc_d     = {crc_q[11:0], crc_q[15:12]};
        chk_cnt_d = chk_cnt_q + 2'd1;
        if (chk_cnt_q == CHECK_LAST) begin
          res_err_d    = chk_bad_d || (chk_pos_d != text_cnt_q);
          res_status_d = ST_CRC_BAD;
          emit_idx_d   = '0;
          state_d      = S_EMIT;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (res_err_q) begin
            status_d      = res_status_q;
            field_index_d = '0;
            field_value_d = '0;
            first_ok_d    = 1'b0;
            last_d        = 1'b1;
            res_err_d     = 1'b0;
            state_d       = S_IDLE;
          end else begin
            status_d      = ST_OK;
            field_index_d = emit_idx_q;
            field_value_d = store_q[emit_idx_q];
            first_ok_d    = (ok_q == OK_GOT_OK);
            last_d        = (emit_idx_q == field_cnt_q);
            if (emit_idx_q == field_cnt_q) begin
              emit_idx_d = '0;
              state_d    = S_IDLE;
            end else begin
              emit_idx_d = emit_idx_q + 1'b1;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= PH_WAIT;
      np_q          <= NP_LEAD;
      ok_q          <= OK_NONE;
      start_char_q  <= 8'd60;
      end_char_q    <= 8'd62;
      sep_char_q    <= 8'd44;
      frame_to_q    <= 16'd1000;
      answer_to_q   <= 16'd5000;
      act_q         <= ACT_BYTE;
      byte_q        <= '0;
      tick_q        <= '0;
      crc_q         <= '0;
      text_cnt_q    <= '0;
      field_cnt_q   <= '0;
      mag_q         <= '0;
      neg_q         <= 1'b0;
      emit_idx_q    <= '0;
      bit_cnt_q     <= '0;
      shift_q       <= '0;
      chk_pos_q     <= '0;
      chk_cnt_q     <= '0;
      chk_started_q <= 1'b0;
      chk_bad_q     <= 1'b0;
      res_err_q     <= 1'b0;
      res_status_q  <= ST_OK;
      out_valid_q   <= 1'b0;
      status_q      <= ST_OK;
      field_index_q <= '0;
      field_value_q <= '0;
      first_ok_q    <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      np_q          <= np_d;
      ok_q          <= ok_d;
      act_q         <= act_d;
      byte_q        <= byte_d;
      tick_q        <= tick_d;
      crc_q         <= crc_d;
      text_cnt_q    <= text_cnt_d;
      field_cnt_q   <= field_cnt_d;
      mag_q         <= mag_d;
      neg_q         <= neg_d;
      emit_idx_q    <= emit_idx_d;
      bit_cnt_q     <= bit_cnt_d;
      shift_q       <= shift_d;
      chk_pos_q     <= chk_pos_d;
      chk_cnt_q     <= chk_cnt_d;
      chk_started_q <= chk_started_d;
      chk_bad_q     <= chk_bad_d;
      res_err_q     <= res_err_d;
      res_status_q  <= res_status_d;
      out_valid_q   <= out_valid_d;
      status_q      <= status_d;
      field_index_q <= field_index_d;
      field_value_q <= field_value_d;
      first_ok_q    <= first_ok_d;
      last_q        <= last_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START_CHAR: start_char_q <= cfg_data_i[7:0];
          CFG_END_CHAR:   end_char_q   <= cfg_data_i[7:0];
          CFG_SEP_CHAR:   sep_char_q   <= cfg_data_i[7:0];
          CFG_FRAME_TO:   frame_to_q   <= cfg_data_i;
          CFG_ANSWER_TO:  answer_to_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_q[store_idx] <= store_wdata;
    if (text_we) text_q[text_cnt_q[1:0]] <= byte_q;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign field_index_o = field_index_q;
  assign field_value_o = field_value_q;
  assign first_is_ok_o = first_ok_q;
  assign last_o        = last_q;

endmodule

FILE: hdl/crcrx_checker.sv
// ---------------------------------------------------------------------------
// crcrx_checker - port level checks for the reply frame receiver
// Watches the result channel and the input ready over time.
// ---------------------------------------------------------------------------
module crcrx_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [crcrx_pkg::STATUS_W-1:0]       status_o,
  input logic [crcrx_pkg::FIELD_IDX_W-1:0]    field_index_o,
  input logic signed [crcrx_pkg::VALUE_W-1:0] field_value_o,
  input logic                                 first_is_ok_o,
  input logic                                 last_o
);
  import crcrx_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(field_index_o) && $stable(field_value_o) && $stable(last_o))
    else $error("result changed while stalled");

  // error results are single, empty items
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && field_index_o == '0 &&
      field_value_o == '0 && !first_is_ok_o)
    else $error("malformed error item");

  // field items follow each other without gaps and in order
  a_field_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && field_index_o == $past(field_index_o) + 3'd1)
    else $error("field sequence broken");

  // no new input while a burst of fields is still going out
  a_busy_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input taken mid burst");

endmodule

bind crc_checked_reply_frame_receiver_unit crcrx_checker u_crcrx_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench - reply frame receiver check
// Feeds framed replies, ticks, arm requests and noise through the input
// channel, predicts every result from a behavioral copy of the receiver and
// compares each result item with the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
  import crcrx_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_LIMIT_NS  = 5_000_000;
  localparam int PHASE_ITEMS   = 95;

  typedef enum logic [1:0] {RX_WAIT, RX_PAYLOAD, RX_CRC_TEXT, RX_DONE} rx_phase_e;
  typedef enum logic [1:0] {NUM_LEAD, NUM_SIGN, NUM_DIGITS, NUM_END} num_state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [7:0]          rx_b;
    logic                drain;
  } rx_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [FIELD_IDX_W-1:0] index;
    logic [VALUE_W-1:0]     value;
    logic                   first_ok;
    logic                   last;
  } field_res_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [ACTION_W-1:0]           action_i;
  logic [7:0]                    rx_byte_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [STATUS_W-1:0]           status_o;
  logic [FIELD_IDX_W-1:0]        field_index_o;
  logic signed [VALUE_W-1:0]     field_value_o;
  logic                          first_is_ok_o;
  logic                          last_o;

  crc_checked_reply_frame_receiver_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .field_index_o (field_index_o),
    .field_value_o (field_value_o),
    .first_is_ok_o (first_is_ok_o),
    .last_o        (last_o)
  );

  rx_item_t   pend_q[$];
  field_res_t exp_q[$];
  logic [7:0] body_q[$];
  rx_item_t   cur_item;
  logic       item_live = 1'b0;
  logic       in_took   = 1'b0;
  int         phase_items;
  int         err_cnt = 0;
  int         snd_idle_pct;
  int         rcv_idle_pct;

  // receiver copy: configuration
  logic [7:0]  cfg_start     = 8'd60;
  logic [7:0]  cfg_end       = 8'd62;
  logic [7:0]  cfg_sep       = 8'd44;
  logic [15:0] cfg_frame_to  = 16'd1000;
  logic [15:0] cfg_answer_to = 16'd5000;

  // receiver copy: state
  rx_phase_e   rx_phase  = RX_WAIT;
  int          tick_cnt  = 0;
  logic [15:0] crc_acc   = '0;
  logic [7:0]  crc_txt [CRC_TEXT_CHARS];
  int          crc_txt_n = 0;
  logic [15:0] field_val [MAX_FIELDS];
  int          field_cur = 0;
  num_state_e  num_st    = NUM_LEAD;
  logic [1:0]  ok_st     = '0;
  int          num_mag   = 0;
  logic        num_neg   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    int k;
    c = crc ^ {d, 8'h00};
    for (k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // number of hex digits in the CRC text, no leading zeros
  function automatic int hex_len(input logic [15:0] v);
    if (v[15:12] != 0) return 4;
    if (v[11:8] != 0) return 3;
    if (v[7:4] != 0) return 2;
    return 1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [15:0] v, input int pos);
    logic [3:0] nib;
    nib = 4'(v >> (4 * (hex_len(v) - 1 - pos)));
    return (nib < 10) ? 8'd48 + nib : 8'd87 + nib;
  endfunction

  function automatic void push_error(input logic [STATUS_W-1:0] st);
    field_res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    exp_q.push_back(r);
    rx_phase = RX_DONE;
  endfunction

  function automatic void open_field();
    num_st = NUM_LEAD;
    num_mag = 0;
    num_neg = 1'b0;
    field_val[field_cur] = '0;
  endfunction

  function automatic void parse_num(input logic [7:0] c);
    logic is_digit;
    logic is_space;
    is_digit = (c >= 8'h30 && c <= 8'h39);
    is_space = (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d));
    case (num_st)
      NUM_LEAD: begin
        if (is_space) return;
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          num_neg = (c == CHAR_MINUS);
          num_st = NUM_SIGN;
          return;
        end
        if (!is_digit) begin
          num_st = NUM_END;
          return;
        end
      end
      NUM_SIGN, NUM_DIGITS: begin
        if (!is_digit) begin
          num_st = NUM_END;
          return;
        end
      end
      default: return;
    endcase
    num_st = NUM_DIGITS;
    num_mag = num_mag * 10 + (int'(c) - 48);
    if (num_mag > 32768) num_mag = 32768;
    field_val[field_cur] = num_neg ? 16'(65536 - num_mag)
                                   : 16'(num_mag > 32767 ? 32767 : num_mag);
  endfunction

  // advance the receiver copy by one accepted item, queue what it emits
  function automatic void predict(input logic [ACTION_W-1:0] act, input logic [7:0] c);
    field_res_t r;
    logic       text_ok;
    int         nf;
    int         i;
    if (act == ACT_ARM) begin
      rx_phase = RX_WAIT;
      tick_cnt = 0;
      return;
    end
    if (act == ACT_TICK) begin
      if (rx_phase == RX_DONE) return;
      if (tick_cnt < 65535) tick_cnt++;
      if (rx_phase == RX_WAIT) begin
        if (tick_cnt >= cfg_answer_to) push_error(ST_NO_REPLY);
      end else if (tick_cnt > cfg_frame_to) begin
        push_error(ST_FRAME_TO);
      end
      return;
    end
    if (act != ACT_BYTE) return;

    if (rx_phase == RX_WAIT) begin
      if (c == cfg_start) begin
        rx_phase = RX_PAYLOAD;
        tick_cnt = 0;
        crc_acc = '0;
        crc_txt_n = 0;
        field_cur = 0;
        ok_st = '0;
        open_field();
      end
      return;
    end
    if (rx_phase == RX_DONE) return;

    if (c == cfg_end) begin
      if (rx_phase == RX_PAYLOAD) begin
        push_error(ST_NO_CRC_SEP);
        return;
      end
      text_ok = (crc_txt_n == hex_len(crc_acc));
      if (text_ok)
        for (i = 0; i < crc_txt_n; i++)
          if (crc_txt[i] != hex_char(crc_acc, i)) text_ok = 1'b0;
      if (!text_ok) begin
        push_error(ST_CRC_BAD);
        return;
      end
      rx_phase = RX_DONE;
      nf = field_cur + 1;
      for (i = 0; i < nf; i++) begin
        r.status = ST_OK;
        r.index = FIELD_IDX_W'(i);
        r.value = field_val[i];
        r.first_ok = (ok_st == 2'd2);
        r.last = (i == nf - 1);
        exp_q.push_back(r);
      end
      return;
    end

    if (rx_phase == RX_CRC_TEXT) begin
      if (crc_txt_n < CRC_TEXT_CHARS) begin
        crc_txt[crc_txt_n] = c;
        crc_txt_n++;
      end
      return;
    end

    if (c == CHAR_PIPE) begin
      rx_phase = RX_CRC_TEXT;
      return;
    end
    crc_acc = crc16_feed(crc_acc, c);
    // past the last field a separator is just text of that field
    if (c == cfg_sep && field_cur + 1 < MAX_FIELDS) begin
      field_cur++;
      open_field();
      return;
    end
    parse_num(c);
    if (field_cur == 0) begin
      case (ok_st)
        2'd0:    ok_st = (c == CHAR_O) ? 2'd1 : 2'd3;
        2'd1:    ok_st = (c == CHAR_K) ? 2'd2 : 2'd3;
        default: ok_st = 2'd3;
      endcase
    end
  endfunction

  function automatic void check_result();
    field_res_t got;
    field_res_t want;
    got.status = status_o;
    got.index = field_index_o;
    got.value = field_value_o;
    got.first_ok = first_is_ok_o;
    got.last = last_o;
    if (exp_q.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected result: status %0d index %0d value %0d ok %0b last %0b",
               $time, got.status, got.index, $signed(got.value), got.first_ok, got.last);
      return;
    end
    want = exp_q.pop_front();
    if (got !== want) begin
      err_cnt++;
      $display("%0t: mismatch: expected status %0d index %0d value %0d ok %0b last %0b",
               $time, want.status, want.index, $signed(want.value), want.first_ok,
               want.last);
      $display("%0t:           got status %0d index %0d value %0d ok %0b last %0b",
               $time, got.status, got.index, $signed(got.value), got.first_ok, got.last);
    end
  endfunction

  // monitor: sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result();
      if (in_valid_i && in_ready_o) begin
        predict(action_i, rx_byte_i);
        in_took = 1'b1;
      end
    end
  end

  // driver: change inputs at the falling edge
  always @(negedge clk_i) begin
    if (in_took) begin
      item_live = 1'b0;
      in_took = 1'b0;
    end
    if (rst_ni && !item_live && pend_q.size() > 0 &&
        !(pend_q[0].drain && exp_q.size() > 0) &&
        $urandom_range(99) >= snd_idle_pct) begin
      cur_item = pend_q.pop_front();
      item_live = 1'b1;
      action_i <= cur_item.act;
      rx_byte_i <= cur_item.rx_b;
    end
    in_valid_i <= item_live;
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic add_item(input logic [ACTION_W-1:0] act, input logic [7:0] c,
                          input logic drain);
    rx_item_t it;
    it.act = act;
    it.rx_b = c;
    it.drain = drain;
    pend_q.push_back(it);
    phase_items++;
  endtask

  function automatic logic [7:0] payload_char(input logic [7:0] c);
    return (c == cfg_end || c == CHAR_PIPE) ? 8'h78 : c;
  endfunction

  function automatic logic [7:0] ws_char(input int k);
    case (k)
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0a;
      3:       return 8'h0b;
      4:       return 8'h0c;
      default: return 8'h0d;
    endcase
  endfunction

  task automatic add_field(input logic first);
    int n;
    if (first && $urandom_range(2) == 0) begin
      body_q.push_back(CHAR_O);
      body_q.push_back(CHAR_K);
      if ($urandom_range(4) == 0) body_q.push_back(payload_char(8'($urandom_range(255))));
      return;
    end
    if ($urandom_range(2) == 0)
      repeat ($urandom_range(1, 2)) body_q.push_back(ws_char($urandom_range(5)));
    case ($urandom_range(3))
      1:       body_q.push_back(CHAR_PLUS);
      2:       body_q.push_back(CHAR_MINUS);
      default: ;
    endcase
    n = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
    repeat (n) body_q.push_back(8'h30 + 8'($urandom_range(9)));
    if ($urandom_range(5) == 0) body_q.push_back(payload_char(8'($urandom_range(255))));
  endtask

  // payload from body_q, then '|', CRC text and end_char
  // flaw: 0 none, 1 wrong digit, 2 short text, 3 leading zero, 4 extra char,
  // negative leaves out the '|' and the text
  task automatic send_body(input int tick_at, input int flaw);
    logic [15:0] crc;
    logic [7:0]  txt[$];
    int          i;
    crc = '0;
    for (i = 0; i < body_q.size(); i++) begin
      if (i == tick_at) add_item(ACT_TICK, 8'($urandom_range(255)), 1'b0);
      crc = crc16_feed(crc, body_q[i]);
      add_item(ACT_BYTE, body_q[i], 1'b0);
    end
    if (flaw < 0) begin
      add_item(ACT_BYTE, cfg_end, 1'b0);
      return;
    end
    for (i = 0; i < hex_len(crc); i++) txt.push_back(hex_char(crc, i));
    case (flaw)
      1:       txt[0] ^= 8'h01;
      2:       void'(txt.pop_back());
      3:       txt.push_front(8'h30);
      4:       txt.push_back(8'h61);
      default: ;
    endcase
    add_item(ACT_BYTE, CHAR_PIPE, 1'b0);
    for (i = 0; i < txt.size(); i++) add_item(ACT_BYTE, txt[i], 1'b0);
    add_item(ACT_BYTE, cfg_end, 1'b0);
  endtask

  task automatic add_frame(input logic drain);
    int         nfld;
    int         f;
    int         tick_at;
    int         flaw;
    logic [7:0] c;
    add_item(ACT_ARM, 8'($urandom_range(255)), drain);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) begin
        c = 8'($urandom_range(255));
        if ($urandom_range(1)) add_item(ACT_TICK, c, 1'b0);
        else add_item(ACT_BYTE, (c == cfg_start) ? ~c : c, 1'b0);
      end
    add_item(ACT_BYTE, cfg_start, 1'b0);
    body_q.delete();
    nfld = ($urandom_range(6) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 5);
    for (f = 0; f < nfld; f++) begin
      if (f > 0) body_q.push_back(cfg_sep);
      add_field(f == 0);
    end
    tick_at = -1;
    if ($urandom_range(5) == 0) tick_at = $urandom_range(body_q.size());
    flaw = 0;
    if ($urandom_range(19) == 0) flaw = -1;
    else if ($urandom_range(3) == 0) flaw = $urandom_range(1, 4);
    send_body(tick_at, flaw);
  endtask

  // tick runs long enough to hit the timeouts, where they are short
  task automatic add_timeout_run();
    if (cfg_answer_to <= 40) begin
      add_item(ACT_ARM, 8'($urandom_range(255)), 1'b0);
      repeat (cfg_answer_to) add_item(ACT_TICK, 8'($urandom_range(255)), 1'b0);
    end
    if (cfg_frame_to < 40) begin
      add_item(ACT_ARM, 8'($urandom_range(255)), 1'b0);
      add_item(ACT_BYTE, cfg_start, 1'b0);
      add_item(ACT_BYTE, 8'h31, 1'b0);
      repeat (int'(cfg_frame_to) + 1) add_item(ACT_TICK, 8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic add_directed();
    string s;
    int    i;
    // OK flag, both saturation limits, separator
    s = "OK,-40000,99999";
    add_item(ACT_BYTE, cfg_start, 1'b0);
    body_q.delete();
    for (i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    send_body(-1, 0);
    // end_char with no '|'
    add_item(ACT_ARM, 8'h00, 1'b0);
    add_item(ACT_BYTE, cfg_start, 1'b0);
    body_q.delete();
    send_body(-1, -1);
    // empty text against the "0" of a zero CRC
    add_item(ACT_ARM, 8'hff, 1'b0);
    add_item(ACT_BYTE, cfg_start, 1'b0);
    send_body(-1, 2);
  endtask

  task automatic add_random_phase();
    logic paused;
    int   sel;
    phase_items = 0;
    paused = 1'b0;
    while (phase_items < PHASE_ITEMS) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        repeat ($urandom_range(1, 4))
          add_item(ACT_ARM + ACTION_W'($urandom_range(1)), 8'($urandom_range(255)), 1'b0);
        add_item(ACTION_W'($urandom_range(3)), 8'($urandom_range(255)), 1'b0);
      end else if (sel == 1) begin
        add_timeout_run();
      end else begin
        // hold the sender until all results are in: first frame past mid-phase, or at random
        add_frame((!paused && phase_items > PHASE_ITEMS / 2) || $urandom_range(9) == 0);
        if (phase_items > PHASE_ITEMS / 2) paused = 1'b1;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || item_live || exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_START_CHAR: cfg_start = val[7:0];
      CFG_END_CHAR:   cfg_end = val[7:0];
      CFG_SEP_CHAR:   cfg_sep = val[7:0];
      CFG_FRAME_TO:   cfg_frame_to = val;
      CFG_ANSWER_TO:  cfg_answer_to = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] st, input logic [7:0] en, input logic [7:0] sp,
                            input logic [15:0] fto, input logic [15:0] ato);
    cfg_write(CFG_START_CHAR, {8'h00, st});
    cfg_write(CFG_END_CHAR, {8'h00, en});
    cfg_write(CFG_SEP_CHAR, {8'h00, sp});
    cfg_write(CFG_FRAME_TO, fto);
    cfg_write(CFG_ANSWER_TO, ato);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i = ACT_BYTE;
    rx_byte_i = '0;
    out_ready_i = 1'b0;
    snd_idle_pct = 34;
    rcv_idle_pct = 77;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_directed();
    wait_idle();
    add_random_phase();
    wait_idle();

    set_config(8'h00, 8'hff, 8'h3b, 16'd0, 16'd1);
    add_random_phase();
    wait_idle();

    snd_idle_pct = 77;
    rcv_idle_pct = 34;
    set_config(8'h7b, 8'h7d, 8'hff, 16'hffff, 16'hffff);
    add_random_phase();
    wait_idle();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(8'h3c, 8'h3e, 8'h2c, 16'd25, 16'd12);
    add_random_phase();
    wait_idle();

    if (err_cnt == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: files.f
hdl/crcrx_pkg.sv
hdl/crc_checked_reply_frame_receiver_unit.sv
hdl/crcrx_checker.sv
tb/testbench.sv
